/* sv/ufwm_pkg.sv */
// Package for the union-find wall merge block.
// Field widths, exit bit codes, controller states and the command/status structs.
// No dependencies.
package ufwm_pkg;

  localparam int CELL_W        = 12;
  localparam int MAP_W         = 8;
  localparam int HGT_W         = 12;
  localparam int MAX_CELLS_DEF = 4096;

  localparam logic [HGT_W-1:0] HGT_RESET = 12'd64;

  // Exit map bits
  localparam logic [MAP_W-1:0] EX_UP    = 8'd1;
  localparam logic [MAP_W-1:0] EX_DOWN  = 8'd2;
  localparam logic [MAP_W-1:0] EX_LDOWN = 8'd4;
  localparam logic [MAP_W-1:0] EX_RDOWN = 8'd8;
  localparam logic [MAP_W-1:0] EX_LEQ   = 8'd16;
  localparam logic [MAP_W-1:0] EX_REQ   = 8'd32;
  localparam logic [MAP_W-1:0] EX_LUP   = 8'd64;
  localparam logic [MAP_W-1:0] EX_RUP   = 8'd128;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_FRD,
    S_FCHK,
    S_CRD,
    S_CWR,
    S_MRG1,
    S_MRG2,
    S_XRDL,
    S_XRDH,
    S_XCAPH,
    S_XWRL,
    S_XWRH,
    S_OUT
  } ufwm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic load_item;
    logic find_start;
    logic find_sel;
    logic root_step;
    logic save_root;
    logic rd_walk;
    logic comp_wr;
    logic merge_child;
    logic merge_root;
    logic ex_rd_hi;
    logic cap_lo;
    logic cap_hi;
    logic ex_wr_lo;
    logic ex_wr_hi;
    logic out_load;
  } ufwm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic pdata_neg;
    logic walk_eq_root;
    logic roots_eq;
    logic both_ok;
    logic out_free;
  } ufwm_status_t;

endpackage

/* sv/ufwm_if.sv */
// Channel interfaces: wall input, result output and configuration write.
// Depends on ufwm_pkg for field widths.
interface ufwm_wall_if;
  logic                          valid;
  logic                          ready;
  logic [ufwm_pkg::CELL_W-1:0]   lower_cell;
  logic [ufwm_pkg::CELL_W-1:0]   higher_cell;
  modport source (output valid, output lower_cell, output higher_cell, input ready);
  modport sink   (input valid, input lower_cell, input higher_cell, output ready);
endinterface

interface ufwm_res_if;
  logic                          valid;
  logic                          ready;
  logic                          wall_removed;
  logic [ufwm_pkg::MAP_W-1:0]    lower_exits;
  logic [ufwm_pkg::MAP_W-1:0]    higher_exits;
  modport source (output valid, output wall_removed, output lower_exits,
                  output higher_exits, input ready);
  modport sink   (input valid, input wall_removed, input lower_exits,
                  input higher_exits, output ready);
endinterface

interface ufwm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ufwm_pkg::HGT_W-1:0]    column_height;
  modport source (output valid, output column_height, input ready);
  modport sink   (input valid, input column_height, output ready);
endinterface

/* sv/ufwm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ufwm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/ufwm_ctrl.sv */
// Controller state machine: clearing pass, two root walks with compression,
// merge and exit map update. Depends on ufwm_pkg.
module ufwm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ufwm_pkg::ufwm_status_t sts,
  output ufwm_pkg::ufwm_cmd_t    cmd
);
  import ufwm_pkg::*;

  ufwm_state_t state, state_next;
  logic        sel, sel_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    sel_next     = sel;
    cmd          = '0;
    cmd.find_sel = sel;
    in_ready     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_START;
        end
      end
      S_START: begin
        if (sts.both_ok) begin
          cmd.find_start = 1'b1;
          cmd.find_sel   = 1'b0;
          sel_next       = 1'b0;
          state_next     = S_FRD;
        end else begin
          state_next = S_XRDL;
        end
      end
      // parent of current root is being read
      S_FRD: state_next = S_FCHK;
      S_FCHK: begin
        if (sts.pdata_neg) begin
          cmd.save_root = 1'b1;
          state_next    = S_CRD;
        end else begin
          cmd.root_step = 1'b1;
          state_next    = S_FRD;
        end
      end
      // compression walk
      S_CRD: begin
        if (sts.walk_eq_root) begin
          if (!sel) begin
            cmd.find_start = 1'b1;
            cmd.find_sel   = 1'b1;
            sel_next       = 1'b1;
            state_next     = S_FRD;
          end else if (sts.roots_eq) begin
            state_next = S_XRDL;
          end else begin
            state_next = S_MRG1;
          end
        end else begin
          cmd.rd_walk = 1'b1;
          state_next  = S_CWR;
        end
      end
      S_CWR: begin
        cmd.comp_wr = 1'b1;
        state_next  = S_CRD;
      end
      S_MRG1: begin
        cmd.merge_child = 1'b1;
        state_next      = S_MRG2;
      end
      S_MRG2: begin
        cmd.merge_root = 1'b1;
        state_next     = S_XRDL;
      end
      S_XRDL: state_next = S_XRDH;
      S_XRDH: begin
        cmd.ex_rd_hi = 1'b1;
        cmd.cap_lo   = 1'b1;
        state_next   = S_XCAPH;
      end
      S_XCAPH: begin
        cmd.cap_hi = 1'b1;
        state_next = S_XWRL;
      end
      S_XWRL: begin
        cmd.ex_wr_lo = 1'b1;
        state_next   = S_XWRH;
      end
      S_XWRH: begin
        cmd.ex_wr_hi = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

/* sv/ufwm_dp.sv */
// Datapath: parent and exit stores, walk registers, direction decode and
// result register. Depends on ufwm_pkg and ufwm_ram.
module ufwm_dp #(
  parameter int MAX_CELLS = ufwm_pkg::MAX_CELLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ufwm_pkg::ufwm_cmd_t           cmd,
  output ufwm_pkg::ufwm_status_t        sts,
  input  logic [ufwm_pkg::CELL_W-1:0]   lower_cell,
  input  logic [ufwm_pkg::CELL_W-1:0]   higher_cell,
  input  logic                          cfg_valid,
  input  logic [ufwm_pkg::HGT_W-1:0]    cfg_height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_removed,
  output logic [ufwm_pkg::MAP_W-1:0]    out_lower,
  output logic [ufwm_pkg::MAP_W-1:0]    out_higher
);
  import ufwm_pkg::*;

  localparam int          AW = $clog2(MAX_CELLS);
  localparam int          PW = AW + 2;
  localparam int unsigned MC = MAX_CELLS;

  logic [HGT_W-1:0]  col_h;
  logic [CELL_W-1:0] lo_cell, hi_cell;
  logic              lo_ok, hi_ok;
  logic [AW-1:0]     clr_idx;
  logic [AW-1:0]     root, walk, rx, ry;
  logic signed [PW-1:0] sx, sy;
  logic [MAP_W-1:0]  lo_map, hi_map;
  logic              removed;

  logic          p_we, x_we;
  logic [AW-1:0] p_waddr, p_raddr, x_waddr, x_raddr;
  logic [PW-1:0] p_wdata, p_rdata;
  logic [MAP_W-1:0] x_wdata, x_rdata;

  logic [AW-1:0] lo_addr, hi_addr, surv, child, pnext;
  logic          lo_wins;
  logic signed [PW-1:0] size_sum;
  logic [MAP_W-1:0] lbit, hbit, lo_new, hi_new;
  logic signed [CELL_W:0]   dlt;
  logic signed [CELL_W+1:0] kpos, kneg;

  assign lo_addr  = AW'(lo_cell);
  assign hi_addr  = AW'(hi_cell);
  assign pnext    = AW'(p_rdata);
  assign lo_wins  = sx < sy;
  assign surv     = lo_wins ? rx : ry;
  assign child    = lo_wins ? ry : rx;
  assign size_sum = sx + sy;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      col_h <= HGT_RESET;
    end else if (cfg_valid) begin
      col_h <= cfg_height;
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_en) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      lo_cell <= lower_cell;
      hi_cell <= higher_cell;
      lo_ok   <= 32'(lower_cell) < MC;
      hi_ok   <= 32'(higher_cell) < MC;
      removed <= 1'b0;
    end
    if (cmd.find_start) begin
      root <= cmd.find_sel ? hi_addr : lo_addr;
      walk <= cmd.find_sel ? hi_addr : lo_addr;
    end
    if (cmd.root_step) begin
      root <= pnext;
    end
    if (cmd.save_root) begin
      if (cmd.find_sel) begin
        ry <= root;
        sy <= p_rdata;
      end else begin
        rx <= root;
        sx <= p_rdata;
      end
    end
    if (cmd.comp_wr) begin
      walk <= pnext;
    end
    if (cmd.merge_root) begin
      removed <= 1'b1;
    end
    if (cmd.cap_lo) begin
      lo_map <= x_rdata;
    end
    if (cmd.cap_hi) begin
      hi_map <= x_rdata;
    end
    if (cmd.ex_wr_lo) begin
      lo_map <= lo_new;
    end
    if (cmd.ex_wr_hi) begin
      hi_map <= hi_new;
    end
  end

  // Parent store port mux
  always_comb begin
    p_we    = 1'b0;
    p_waddr = clr_idx;
    p_wdata = '1;
    if (cmd.clr_en) begin
      p_we = 1'b1;
    end else if (cmd.comp_wr) begin
      p_we    = 1'b1;
      p_waddr = walk;
      p_wdata = PW'(root);
    end else if (cmd.merge_child) begin
      p_we    = 1'b1;
      p_waddr = child;
      p_wdata = PW'(surv);
    end else if (cmd.merge_root) begin
      p_we    = 1'b1;
      p_waddr = surv;
      p_wdata = size_sum;
    end
  end
  assign p_raddr = cmd.rd_walk ? walk : root;

  // Direction decode
  always_comb begin
    dlt  = $signed({1'b0, hi_cell}) - $signed({1'b0, lo_cell});
    kpos = (CELL_W+2)'(dlt) - $signed({2'b00, col_h});
    kneg = (CELL_W+2)'(dlt) + $signed({2'b00, col_h});
    lbit = '0;
    hbit = '0;
    if (dlt == 1) begin
      hbit = EX_DOWN;
      lbit = EX_UP;
    end else if (dlt > 0) begin
      if (kpos == -1) begin
        hbit = EX_LUP;   lbit = EX_RDOWN;
      end else if (kpos == 0) begin
        hbit = EX_LEQ;   lbit = EX_REQ;
      end else if (kpos == 1) begin
        hbit = EX_LDOWN; lbit = EX_RUP;
      end
    end else begin
      if (kneg == -1) begin
        hbit = EX_RUP;   lbit = EX_LDOWN;
      end else if (kneg == 0) begin
        hbit = EX_REQ;   lbit = EX_LEQ;
      end else if (kneg == 1) begin
        hbit = EX_RDOWN; lbit = EX_LUP;
      end
    end
  end
  assign lo_new = removed ? (lo_map | lbit) : lo_map;
  assign hi_new = removed ? (hi_map | hbit) : hi_map;

  // Exit store port mux
  always_comb begin
    x_we    = 1'b0;
    x_waddr = clr_idx;
    x_wdata = '0;
    if (cmd.clr_en) begin
      x_we = 1'b1;
    end else if (cmd.ex_wr_lo) begin
      x_we    = removed;
      x_waddr = lo_addr;
      x_wdata = lo_new;
    end else if (cmd.ex_wr_hi) begin
      x_we    = removed;
      x_waddr = hi_addr;
      x_wdata = hi_new;
    end
  end
  assign x_raddr = cmd.ex_rd_hi ? hi_addr : lo_addr;

  ufwm_ram #(.W(PW), .D(MAX_CELLS)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  ufwm_ram #(.W(MAP_W), .D(MAX_CELLS)) u_exits (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_removed <= removed;
      out_lower   <= lo_ok ? lo_map : '0;
      out_higher  <= hi_ok ? hi_map : '0;
    end
  end

  // Status to controller
  assign sts.clear_done   = clr_idx == AW'(MAX_CELLS - 1);
  assign sts.pdata_neg    = p_rdata[PW-1];
  assign sts.walk_eq_root = walk == root;
  assign sts.roots_eq     = rx == ry;
  assign sts.both_ok      = lo_ok && hi_ok;
  assign sts.out_free     = !out_valid || out_ready;
endmodule

/* sv/union_find_wall_merge.sv */
// Channel    Dir   Handshake      Word
// wall_in    in    valid/ready    lower_cell, higher_cell
// result_out out   valid/ready    wall_removed, lower_exits, higher_exits
// cfg        in    valid/ready    column_height (always ready)
//
// After reset the parent and exit stores are cleared, one entry per cycle,
// with wall_in not ready. Config writes are taken meanwhile. One wall is
// worked at a time: a merged wall has two root searches with compression,
// the merge and the exit map update; a kept wall skips the merge, and an
// out-of-range wall goes straight to the exit map update. The result register
// lets the next wall enter while a result waits; a second result stalls.
//
// Top level of the union-find wall merge. Depends on ufwm_pkg, ufwm_if,
// ufwm_ctrl and ufwm_dp.
module union_find_wall_merge #(
  parameter int MAX_CELLS = ufwm_pkg::MAX_CELLS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  ufwm_wall_if.sink      wall_in,
  ufwm_res_if.source     result_out,
  ufwm_cfg_if.sink       cfg
);
  import ufwm_pkg::*;

  ufwm_cmd_t    cmd;
  ufwm_status_t sts;

  assign cfg.ready = 1'b1;

  ufwm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(wall_in.valid), .in_ready(wall_in.ready),
    .sts(sts), .cmd(cmd)
  );

  ufwm_dp #(.MAX_CELLS(MAX_CELLS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .lower_cell(wall_in.lower_cell), .higher_cell(wall_in.higher_cell),
    .cfg_valid(cfg.valid), .cfg_height(cfg.column_height),
    .out_valid(result_out.valid), .out_ready(result_out.ready),
    .out_removed(result_out.wall_removed),
    .out_lower(result_out.lower_exits), .out_higher(result_out.higher_exits)
  );

  // A loaded result shows up on the port next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> result_out.valid)
    else $error("result not presented after load");

  // Merges only happen for in-range walls with distinct roots
  a_merge_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.merge_root |-> (sts.both_ok && !sts.roots_eq))
    else $error("merge with shared root or bad cell");

  // One wall in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (wall_in.valid && wall_in.ready) |=> !wall_in.ready)
    else $error("second wall taken while busy");
endmodule
